/* hdl/hill_pkg.sv */
// ----------------------------------------------------------------------------
// Hill cipher 2x2 mod 26 package
// Word types, register indexes and modulo 26 helper functions.
// ----------------------------------------------------------------------------
`default_nettype none

package hill_pkg;

   localparam int unsigned LETTER_W = 5;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 5;
   localparam logic [LETTER_W-1:0] MODULUS = 5'd26;

   localparam logic [CSR_IDX_W-1:0] CSR_KEY00 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY01 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY10 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY11 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DECRYPT = 3'd4;

   typedef struct packed {
      logic [LETTER_W-1:0] letter_first;
      logic [LETTER_W-1:0] letter_second;
      logic                last_pair;
   } req_type;

   typedef struct packed {
      logic [LETTER_W-1:0] out_first;
      logic [LETTER_W-1:0] out_second;
      logic                key_not_invertible;
      logic                end_of_message;
   } rsp_type;

   // Reduces a 5-bit value below 32 into 0..25.
   function automatic logic [LETTER_W-1:0] red26(input logic [LETTER_W-1:0] x);
      red26 = (x >= MODULUS) ? (x - MODULUS) : x;
   endfunction

   // Remainder modulo 26 of an 11-bit value by reciprocal multiplication.
   // The quotient estimate is at most one too low, so one correction suffices.
   function automatic logic [LETTER_W-1:0] mod26(input logic [10:0] x);
      logic [19:0] prod;
      logic [6:0]  quo;
      logic [11:0] rem;
      prod = {9'd0, x} * 20'd315;
      quo = prod[19:13];
      rem = {1'b0, x} - ({5'd0, quo} * 12'd26);
      if (rem >= 12'd26) begin
         rem = rem - 12'd26;
      end
      mod26 = rem[LETTER_W-1:0];
   endfunction

   // Multiplicative inverse modulo 26; zero means there is none.
   function automatic logic [LETTER_W-1:0] inv26(input logic [LETTER_W-1:0] x);
      case (x)
         5'd1:    inv26 = 5'd1;
         5'd3:    inv26 = 5'd9;
         5'd5:    inv26 = 5'd21;
         5'd7:    inv26 = 5'd15;
         5'd9:    inv26 = 5'd3;
         5'd11:   inv26 = 5'd19;
         5'd15:   inv26 = 5'd7;
         5'd17:   inv26 = 5'd23;
         5'd19:   inv26 = 5'd11;
         5'd21:   inv26 = 5'd5;
         5'd23:   inv26 = 5'd17;
         5'd25:   inv26 = 5'd25;
         default: inv26 = 5'd0;
      endcase
   endfunction

endpackage

`default_nettype wire

/* hdl/hill_cipher_2x2_mod26_top.sv */
// ----------------------------------------------------------------------------
// Hill cipher 2x2 mod 26 engine
// Encrypts or decrypts letter pairs with a configured 2x2 key matrix.
// ----------------------------------------------------------------------------
// Usage:
// The key entries and the decrypt mode are written through the csr_ port
// (csr_we, csr_index, csr_wdata); the user must write them only while no word
// is in flight, as the block itself does not enforce it. A pair enters as one
// req_data word at a rising edge where start is high and busy is low. Busy is
// always low: the engine takes one word in every cycle. Each word yields
// exactly one rsp_data word, shown for one cycle with rsp_strobe high. Words
// leave in order. The pipeline steps are key reduction, determinant products,
// residues, inverse lookup, adjugate products, inverse key residues, vector
// products and the final residue.
// In decrypt mode a key without an inverse modulo 26 gives zero letters and
// key_not_invertible set.
// Reset clears the key registers, the mode and all words in flight.
// The receiver cannot stall, so the pipeline always advances.
// ----------------------------------------------------------------------------
`default_nettype none

module hill_cipher_2x2_mod26_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire hill_pkg::req_type                    req_data,
   output logic                                      rsp_strobe,
   output hill_pkg::rsp_type                         rsp_data,
   input  wire logic                                 csr_we,
   input  wire logic [hill_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [hill_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int unsigned W = hill_pkg::LETTER_W;
   localparam int unsigned STAGES = 7;

   logic [W-1:0] key00_ff, key01_ff, key10_ff, key11_ff;
   logic         decrypt_ff;

   logic [STAGES-1:0] valid_ff, valid_in;

   // Stage 1
   logic [W-1:0]   s1_m00_ff, s1_m01_ff, s1_m10_ff, s1_m11_ff;
   logic [W-1:0]   s1_p0_ff, s1_p1_ff;
   logic [2*W-1:0] s1_pa_ff, s1_pb_ff;
   logic           s1_dec_ff, s1_last_ff;
   logic [W-1:0]   s1_m00_in, s1_m01_in, s1_m10_in, s1_m11_in;

   // Stage 2
   logic [W-1:0] s2_m00_ff, s2_m01_ff, s2_m10_ff, s2_m11_ff;
   logic [W-1:0] s2_p0_ff, s2_p1_ff;
   logic [W-1:0] s2_ra_ff, s2_rb_ff;
   logic         s2_dec_ff, s2_last_ff;

   // Stage 3
   logic [W-1:0] s3_m00_ff, s3_m01_ff, s3_m10_ff, s3_m11_ff;
   logic [W-1:0] s3_p0_ff, s3_p1_ff;
   logic [W-1:0] s3_dinv_ff;
   logic         s3_dec_ff, s3_last_ff, s3_bad_ff;
   logic [W-1:0] s3_det_in, s3_dinv_in;

   // Stage 4
   logic [W-1:0]   s4_m00_ff, s4_m01_ff, s4_m10_ff, s4_m11_ff;
   logic [W-1:0]   s4_p0_ff, s4_p1_ff;
   logic [2*W-1:0] s4_q00_ff, s4_q01_ff, s4_q10_ff, s4_q11_ff;
   logic           s4_dec_ff, s4_last_ff, s4_bad_ff;

   // Stage 5
   logic [W-1:0] s5_e00_ff, s5_e01_ff, s5_e10_ff, s5_e11_ff;
   logic [W-1:0] s5_p0_ff, s5_p1_ff;
   logic         s5_last_ff, s5_bad_ff;
   logic [W-1:0] s5_r01_in, s5_r10_in;

   // Stage 6
   logic [2*W:0] s6_sum0_ff, s6_sum1_ff;
   logic         s6_last_ff, s6_bad_ff;

   // Stage 7
   hill_pkg::rsp_type s7_rsp_ff, s7_rsp_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         key00_ff <= '0;
         key01_ff <= '0;
         key10_ff <= '0;
         key11_ff <= '0;
         decrypt_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            hill_pkg::CSR_KEY00:   key00_ff <= csr_wdata[W-1:0];
            hill_pkg::CSR_KEY01:   key01_ff <= csr_wdata[W-1:0];
            hill_pkg::CSR_KEY10:   key10_ff <= csr_wdata[W-1:0];
            hill_pkg::CSR_KEY11:   key11_ff <= csr_wdata[W-1:0];
            hill_pkg::CSR_DECRYPT: decrypt_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;
   assign valid_in = {valid_ff[STAGES-2:0], start};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign s1_m00_in = hill_pkg::red26(key00_ff);
   assign s1_m01_in = hill_pkg::red26(key01_ff);
   assign s1_m10_in = hill_pkg::red26(key10_ff);
   assign s1_m11_in = hill_pkg::red26(key11_ff);

   assign s3_det_in = (s2_ra_ff >= s2_rb_ff) ? (s2_ra_ff - s2_rb_ff)
                                             : (s2_ra_ff + hill_pkg::MODULUS - s2_rb_ff);
   assign s3_dinv_in = hill_pkg::inv26(s3_det_in);

   assign s5_r01_in = hill_pkg::mod26({1'b0, s4_q01_ff});
   assign s5_r10_in = hill_pkg::mod26({1'b0, s4_q10_ff});

   always_comb begin
      s7_rsp_in.out_first = s6_bad_ff ? '0 : hill_pkg::mod26(s6_sum0_ff);
      s7_rsp_in.out_second = s6_bad_ff ? '0 : hill_pkg::mod26(s6_sum1_ff);
      s7_rsp_in.key_not_invertible = s6_bad_ff;
      s7_rsp_in.end_of_message = s6_last_ff;
   end

   always_ff @(posedge clock) begin
      s1_m00_ff <= s1_m00_in;
      s1_m01_ff <= s1_m01_in;
      s1_m10_ff <= s1_m10_in;
      s1_m11_ff <= s1_m11_in;
      s1_p0_ff <= hill_pkg::red26(req_data.letter_first);
      s1_p1_ff <= hill_pkg::red26(req_data.letter_second);
      s1_pa_ff <= {{W{1'b0}}, s1_m00_in} * {{W{1'b0}}, s1_m11_in};
      s1_pb_ff <= {{W{1'b0}}, s1_m01_in} * {{W{1'b0}}, s1_m10_in};
      s1_dec_ff <= decrypt_ff;
      s1_last_ff <= req_data.last_pair;

      s2_m00_ff <= s1_m00_ff;
      s2_m01_ff <= s1_m01_ff;
      s2_m10_ff <= s1_m10_ff;
      s2_m11_ff <= s1_m11_ff;
      s2_p0_ff <= s1_p0_ff;
      s2_p1_ff <= s1_p1_ff;
      s2_ra_ff <= hill_pkg::mod26({1'b0, s1_pa_ff});
      s2_rb_ff <= hill_pkg::mod26({1'b0, s1_pb_ff});
      s2_dec_ff <= s1_dec_ff;
      s2_last_ff <= s1_last_ff;

      s3_m00_ff <= s2_m00_ff;
      s3_m01_ff <= s2_m01_ff;
      s3_m10_ff <= s2_m10_ff;
      s3_m11_ff <= s2_m11_ff;
      s3_p0_ff <= s2_p0_ff;
      s3_p1_ff <= s2_p1_ff;
      s3_dinv_ff <= s3_dinv_in;
      s3_bad_ff <= s2_dec_ff && (s3_dinv_in == '0);
      s3_dec_ff <= s2_dec_ff;
      s3_last_ff <= s2_last_ff;

      s4_m00_ff <= s3_m00_ff;
      s4_m01_ff <= s3_m01_ff;
      s4_m10_ff <= s3_m10_ff;
      s4_m11_ff <= s3_m11_ff;
      s4_p0_ff <= s3_p0_ff;
      s4_p1_ff <= s3_p1_ff;
      s4_q00_ff <= {{W{1'b0}}, s3_m11_ff} * {{W{1'b0}}, s3_dinv_ff};
      s4_q11_ff <= {{W{1'b0}}, s3_m00_ff} * {{W{1'b0}}, s3_dinv_ff};
      s4_q01_ff <= {{W{1'b0}}, s3_m01_ff} * {{W{1'b0}}, s3_dinv_ff};
      s4_q10_ff <= {{W{1'b0}}, s3_m10_ff} * {{W{1'b0}}, s3_dinv_ff};
      s4_bad_ff <= s3_bad_ff;
      s4_dec_ff <= s3_dec_ff;
      s4_last_ff <= s3_last_ff;

      if (s4_dec_ff) begin
         s5_e00_ff <= hill_pkg::mod26({1'b0, s4_q00_ff});
         s5_e11_ff <= hill_pkg::mod26({1'b0, s4_q11_ff});
         s5_e01_ff <= (s5_r01_in == '0) ? '0 : (hill_pkg::MODULUS - s5_r01_in);
         s5_e10_ff <= (s5_r10_in == '0) ? '0 : (hill_pkg::MODULUS - s5_r10_in);
      end else begin
         s5_e00_ff <= s4_m00_ff;
         s5_e11_ff <= s4_m11_ff;
         s5_e01_ff <= s4_m01_ff;
         s5_e10_ff <= s4_m10_ff;
      end
      s5_p0_ff <= s4_p0_ff;
      s5_p1_ff <= s4_p1_ff;
      s5_bad_ff <= s4_bad_ff;
      s5_last_ff <= s4_last_ff;

      s6_sum0_ff <= ({{(W+1){1'b0}}, s5_e00_ff} * {{(W+1){1'b0}}, s5_p0_ff})
                  + ({{(W+1){1'b0}}, s5_e01_ff} * {{(W+1){1'b0}}, s5_p1_ff});
      s6_sum1_ff <= ({{(W+1){1'b0}}, s5_e10_ff} * {{(W+1){1'b0}}, s5_p0_ff})
                  + ({{(W+1){1'b0}}, s5_e11_ff} * {{(W+1){1'b0}}, s5_p1_ff});
      s6_bad_ff <= s5_bad_ff;
      s6_last_ff <= s5_last_ff;

      s7_rsp_ff <= s7_rsp_in;
   end

   assign rsp_strobe = valid_ff[STAGES-1];
   assign rsp_data = s7_rsp_ff;

endmodule

`default_nettype wire
